// File: hw/rtl/pltacc_pkg.sv
// ----------------------------------------------------------------------------
// Point light tint accumulator package
// Shared types and fixed constants of the accumulator controller and datapath.
// ----------------------------------------------------------------------------
package pltacc_pkg;

  // Field widths that the interface fixes.
  localparam int unsigned HalfW  = 10;  // light center, half-cell units
  localparam int unsigned CellW  = 9;   // cell coordinate
  localparam int unsigned ReachW = 16;
  localparam int unsigned TintW  = 16;  // signed Q4.12

  // Iteration counts of the shared arithmetic units.
  localparam int unsigned SqrtSteps = 30;  // result bits of the square root
  localparam int unsigned DivSteps  = 13;  // weight bits, weight is at most 4096
  localparam int unsigned NumCh     = 4;   // ambient, red, green, blue
  localparam int unsigned IterW     = 5;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_EVAL  = 2'd2
  } kind_e;

  // One stored light.
  typedef struct packed {
    logic        [HalfW-1:0]  pos_y;
    logic        [HalfW-1:0]  pos_x;
    logic        [ReachW-1:0] reach;
    logic signed [TintW-1:0]  strength;
    logic signed [TintW-1:0]  red;
    logic signed [TintW-1:0]  green;
    logic signed [TintW-1:0]  blue;
  } light_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_cell;
    logic       clear_sums;
    logic       latch_entry;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       mac_step;
    logic [1:0] ch;
    logic       load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
  } dp_stat_t;

endpackage

// File: hw/rtl/pltacc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pltacc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pltacc_dp.sv
// ----------------------------------------------------------------------------
// Point light tint accumulator datapath
// Distance test, digit-by-digit square root, restoring divide and the
// saturating multiply-accumulate of the four tint sums.
// ----------------------------------------------------------------------------
module pltacc_dp import pltacc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic        [CellW-1:0]  cell_x_i,
  input  logic        [CellW-1:0]  cell_y_i,
  input  light_t                   entry_i,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  output logic signed [TintW-1:0]  ambient_sum_o,
  output logic signed [TintW-1:0]  red_sum_o,
  output logic signed [TintW-1:0]  green_sum_o,
  output logic signed [TintW-1:0]  blue_sum_o
);

  logic                    mode_q;
  logic [HalfW-1:0]        hx_q, hy_q;
  light_t                  ent_q;
  logic [21:0]             d_q, d_d;
  logic [59:0]             rad_q, rad_d;
  logic [31:0]             rem_q, rem_d;
  logic [29:0]             root_q, root_d;
  logic [15:0]             dvr_q, dvr_d;
  logic [DivSteps-1:0]     nlow_q, nlow_d;
  logic [DivSteps-1:0]     w_q, w_d;
  logic signed [TintW-1:0] sum_q [NumCh];
  logic signed [TintW-1:0] out_q [NumCh];

  // Squared distance of the fetched light from the cell center.
  logic signed [HalfW:0]   dx, dy;
  logic signed [21:0]      dxx, dyy;
  logic [31:0]             vv;

  always_comb begin
    dx  = $signed({1'b0, entry_i.pos_x}) - $signed({1'b0, hx_q});
    dy  = $signed({1'b0, entry_i.pos_y}) - $signed({1'b0, hy_q});
    dxx = 22'(dx * dx);
    dyy = 22'(dy * dy);
    d_d = 22'(dxx) + 22'(dyy);
    vv  = ent_q.reach * ent_q.reach;
  end

  assign stat_o.hit = (ent_q.reach != '0) && ({d_q, 14'b0} < 36'(vv));

  // Square root, one result bit per step.
  logic [33:0] rem_sh, trial;
  always_comb begin
    rem_sh = {rem_q, rad_q[59:58]};
    trial  = {2'b00, root_q, 2'b01};
    rad_d  = {rad_q[57:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_d  = 32'(rem_sh - trial);
      root_d = {root_q[28:0], 1'b1};
    end else begin
      rem_d  = rem_sh[31:0];
      root_d = {root_q[28:0], 1'b0};
    end
  end

  // Divide (4096 * reach - root) by reach, one quotient bit per step.
  logic [29:0] num;
  logic [16:0] dt;
  logic        qbit;
  always_comb begin
    num  = 30'({ent_q.reach, 12'b0}) - root_q;
    dt   = {dvr_q, nlow_q[DivSteps-1]};
    qbit = dt >= {1'b0, ent_q.reach};
    if (cmd_i.div_init) begin
      dvr_d  = {1'b0, num[27:13]};
      nlow_d = num[12:0];
      w_d    = '0;
    end else begin
      dvr_d  = qbit ? 16'(dt - {1'b0, ent_q.reach}) : dt[15:0];
      nlow_d = {nlow_q[DivSteps-2:0], 1'b0};
      w_d    = {w_q[DivSteps-2:0], qbit};
    end
  end

  // Weighted term of the current channel, added with saturation.
  logic signed [TintW-1:0] mx;
  logic signed [17:0]      term;
  logic signed [31:0]      prod;
  logic signed [19:0]      contr;
  logic signed [20:0]      acc;
  logic signed [TintW-1:0] sat;
  always_comb begin
    mx = '0;
    if (ent_q.red > mx) begin
      mx = ent_q.red;
    end
    if (ent_q.green > mx) begin
      mx = ent_q.green;
    end
    if (ent_q.blue > mx) begin
      mx = ent_q.blue;
    end
    unique case (cmd_i.ch)
      2'd0:    term = mode_q ? 18'(mx >>> 1) + 18'(ent_q.strength) : 18'(ent_q.strength);
      2'd1:    term = mode_q ? '0 : 18'(ent_q.red);
      2'd2:    term = mode_q ? '0 : 18'(ent_q.green);
      default: term = mode_q ? '0 : 18'(ent_q.blue);
    endcase
    prod  = $signed({1'b0, w_q}) * term;
    contr = prod[31:12];
    acc   = 21'(sum_q[cmd_i.ch]) + 21'(contr);
    if (acc > 21'sd32767) begin
      sat = 16'sh7fff;
    end else if (acc < -21'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = acc[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cell) begin
      hx_q <= {cell_x_i, 1'b0};
      hy_q <= {cell_y_i, 1'b0};
    end
    if (cmd_i.latch_entry) begin
      ent_q <= entry_i;
      d_q   <= d_d;
    end
    if (cmd_i.sqrt_init) begin
      rad_q  <= {d_q, 38'b0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
    if (cmd_i.div_init || cmd_i.div_step) begin
      dvr_q  <= dvr_d;
      nlow_q <= nlow_d;
      w_q    <= w_d;
    end
    if (cmd_i.clear_sums) begin
      for (int i = 0; i < NumCh; i++) begin
        sum_q[i] <= '0;
      end
    end else if (cmd_i.mac_step) begin
      sum_q[cmd_i.ch] <= sat;
    end
    if (cmd_i.load_out) begin
      for (int i = 0; i < NumCh; i++) begin
        out_q[i] <= sum_q[i];
      end
    end
  end

  assign ambient_sum_o = out_q[0];
  assign red_sum_o     = out_q[1];
  assign green_sum_o   = out_q[2];
  assign blue_sum_o    = out_q[3];

endmodule

// File: hw/rtl/pltacc_ctrl.sv
// ----------------------------------------------------------------------------
// Point light tint accumulator controller
// Sequences table updates and the per-light evaluation steps.
// ----------------------------------------------------------------------------
module pltacc_ctrl import pltacc_pkg::*; #(
  parameter int unsigned MAX_LIGHTS = 32,
  parameter int unsigned IdxW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1,
  parameter int unsigned CntW = $clog2(MAX_LIGHTS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              kind_i,
  input  logic signed [TintW-1:0] intensity_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    status_o,
  output logic                    ram_we_o,
  output logic [IdxW-1:0]         ram_waddr_o,
  output logic [IdxW-1:0]         ram_raddr_o,
  input  dp_stat_t                stat_i,
  output dp_cmd_t                 cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_SQRT  = 8'b0001_0000,
    S_PREP  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  // Multiply-accumulate shares the divide state's counter via a flag.
  state_e           state_q, state_d;
  logic             mac_q, mac_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             status_q, status_d;
  logic             out_valid_q, out_valid_d;
  logic             out_status_q, out_status_d;
  logic             accept, dim_light, full, last;

  assign accept    = in_valid_i && in_ready_o;
  assign dim_light = (intensity_i <= 16'sd4) && (intensity_i >= -16'sd4);
  assign full      = count_q == CntW'(MAX_LIGHTS);
  assign last      = (idx_q + CntW'(1)) == count_q;

  always_comb begin
    state_d      = state_q;
    mac_d        = mac_q;
    count_d      = count_q;
    idx_d        = idx_q;
    iter_d       = iter_q;
    status_d     = status_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    ram_we_o     = 1'b0;
    cmd_o        = '0;
    cmd_o.ch     = iter_q[1:0];

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_cell  = 1'b1;
          cmd_o.clear_sums = 1'b1;
          status_d         = 1'b0;
          state_d          = S_RESP;
          unique case (kind_e'(kind_i))
            KIND_CLEAR: count_d = '0;
            KIND_ADD: begin
              if (!dim_light) begin
                if (full) begin
                  status_d = 1'b1;
                end else begin
                  ram_we_o = 1'b1;
                  count_d  = count_q + CntW'(1);
                end
              end
            end
            KIND_EVAL: begin
              idx_d = '0;
              if (count_q != '0) begin
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ:  state_d = S_LOAD;
      S_LOAD: begin
        cmd_o.latch_entry = 1'b1;
        state_d           = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.hit) begin
          cmd_o.sqrt_init = 1'b1;
          iter_d          = IterW'(SqrtSteps - 1);
          state_d         = S_SQRT;
        end else if (last) begin
          state_d = S_RESP;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_READ;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        iter_d          = iter_q - IterW'(1);
        if (iter_q == '0) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.div_init = 1'b1;
        iter_d         = IterW'(DivSteps - 1);
        mac_d          = 1'b0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        iter_d = iter_q - IterW'(1);
        if (!mac_q) begin
          cmd_o.div_step = 1'b1;
          if (iter_q == '0) begin
            mac_d  = 1'b1;
            iter_d = IterW'(NumCh - 1);
          end
        end else begin
          cmd_o.mac_step = 1'b1;
          if (iter_q == '0) begin
            if (last) begin
              state_d = S_RESP;
            end else begin
              idx_d   = idx_q + CntW'(1);
              state_d = S_READ;
            end
          end
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          out_status_d   = status_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mac_q        <= 1'b0;
      count_q      <= '0;
      idx_q        <= '0;
      iter_q       <= '0;
      status_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      mac_q        <= mac_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      iter_q       <= iter_d;
      status_q     <= status_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign ram_waddr_o = count_q[IdxW-1:0];
  assign ram_raddr_o = idx_q[IdxW-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_LIGHTS))
    else $error("light count beyond table size");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !full)
    else $error("table write while full");

  a_empty_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_EVAL && count_q == '0) |=> state_q == S_RESP)
    else $error("evaluate of empty table did not respond at once");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> idx_q < count_q)
    else $error("walk reads past stored lights");

endmodule

// File: hw/rtl/point_light_tint_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Point light tint accumulator
// Table of point lights and per-cell linear-falloff tint sums.
// ----------------------------------------------------------------------------
// Clear and add transactions go from the idle state straight to the response
// state. An evaluate transaction walks the stored lights one at a time: each
// light is read, loaded and tested, and each light within reach then takes 30
// square-root steps, a setup step, 13 divide steps and 4 multiply-accumulate
// steps, one per sum, before the walk moves on; the response state follows the
// last light. A finished response waits in the output register while the next
// transaction is taken.
module point_light_tint_accumulator_unit import pltacc_pkg::*; #(
  parameter int unsigned MAX_LIGHTS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration: lighting mode, 0 colored and 1 ambient only.
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  // Input transactions.
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              kind_i,
  input  logic [HalfW-1:0]        center_x_half_i,
  input  logic [HalfW-1:0]        center_y_half_i,
  input  logic [ReachW-1:0]       reach_i,
  input  logic signed [TintW-1:0] intensity_i,
  input  logic signed [TintW-1:0] red_weight_i,
  input  logic signed [TintW-1:0] green_weight_i,
  input  logic signed [TintW-1:0] blue_weight_i,
  input  logic [CellW-1:0]        cell_x_i,
  input  logic [CellW-1:0]        cell_y_i,
  // Result transactions.
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    status_o,
  output logic signed [TintW-1:0] ambient_sum_o,
  output logic signed [TintW-1:0] red_sum_o,
  output logic signed [TintW-1:0] green_sum_o,
  output logic signed [TintW-1:0] blue_sum_o
);

  localparam int unsigned IdxW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  light_t          wentry, rentry;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  // A new light is written straight from the input fields when accepted.
  always_comb begin
    wentry.pos_x    = center_x_half_i;
    wentry.pos_y    = center_y_half_i;
    wentry.reach    = reach_i;
    wentry.strength = intensity_i;
    wentry.red      = red_weight_i;
    wentry.green    = green_weight_i;
    wentry.blue     = blue_weight_i;
  end

  pltacc_ram #(
    .Width ($bits(light_t)),
    .Depth (MAX_LIGHTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wentry),
    .raddr_i (ram_raddr),
    .rdata_o (rentry)
  );

  pltacc_ctrl #(
    .MAX_LIGHTS (MAX_LIGHTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .intensity_i (intensity_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pltacc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .entry_i       (rentry),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .ambient_sum_o (ambient_sum_o),
    .red_sum_o     (red_sum_o),
    .green_sum_o   (green_sum_o),
    .blue_sum_o    (blue_sum_o)
  );

endmodule

// File: sim/point_light_tint_accumulator_unit_test.sv
// ----------------------------------------------------------------------------
// Point light tint accumulator testbench
// Drives clear, add, evaluate and unused-kind transactions with random idling on
// both sides, predicts every response from its own light table and compares each
// response field by field in a small scoreboard.
// ----------------------------------------------------------------------------
module point_light_tint_accumulator_unit_test;
  import pltacc_pkg::*;

  // Kind code that the block must ignore.
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned TableDepth = 32;

  // One input transaction as the testbench builds it.
  typedef struct {
    logic [1:0]        kind;
    logic [9:0]        cx;
    logic [9:0]        cy;
    logic [15:0]       reach;
    logic signed [15:0] inten;
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic [8:0]        x;
    logic [8:0]        y;
  } light_req_t;

  // One response transaction.
  typedef struct {
    logic              status;
    logic signed [15:0] sums [4];
  } tint_resp_t;

  // The scoreboard keeps its own copy of the light table and the lighting
  // mode, and queues the responses those imply in order of acceptance.
  class tint_scoreboard;
    logic [9:0]  pos_x [TableDepth];
    logic [9:0]  pos_y [TableDepth];
    logic [15:0] reach [TableDepth];
    int          strength [TableDepth];
    int          color [TableDepth][3];
    int unsigned count;
    bit          ambient_only;
    tint_resp_t  pending [$];
    int unsigned n_add, n_eval, n_hits, n_full, n_resp, n_errors;

    function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Adds a Q4.12 product scaled back by 4096 (rounded toward minus
    // infinity) to a running sum that saturates at the 16-bit limits.
    function automatic int sat_accumulate(int acc, longint prod);
      longint s;
      s = longint'(acc) + (prod >>> 12);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return int'(s);
    endfunction

    function automatic void note_input(light_req_t q);
      tint_resp_t e;
      int hx, hy, dx, dy, mx;
      longint unsigned d, v, r;
      longint w;
      e.status = 1'b0;
      for (int k = 0; k < 4; k++) e.sums[k] = '0;
      case (q.kind)
        KIND_CLEAR: count = 0;
        KIND_ADD: begin
          n_add++;
          // Weak lights are silently dropped, a full table flags the add.
          if (q.inten > 4 || q.inten < -4) begin
            if (count >= TableDepth) begin
              e.status = 1'b1;
              n_full++;
            end else begin
              pos_x[count] = q.cx;
              pos_y[count] = q.cy;
              reach[count] = q.reach;
              strength[count] = q.inten;
              color[count][0] = q.red;
              color[count][1] = q.green;
              color[count][2] = q.blue;
              count++;
            end
          end
        end
        KIND_EVAL: begin
          int acc [4];
          n_eval++;
          for (int k = 0; k < 4; k++) acc[k] = 0;
          hx = int'(q.x) * 2;
          hy = int'(q.y) * 2;
          for (int i = 0; i < count; i++) begin
            dx = int'(pos_x[i]) - hx;
            dy = int'(pos_y[i]) - hy;
            d = longint'(dx * dx + dy * dy);
            v = reach[i];
            if (v == 0 || d * 16384 >= v * v) continue;
            n_hits++;
            r = int_root(d << 38);
            w = longint'((4096 * v - r) / v);
            if (ambient_only) begin
              mx = 0;
              for (int j = 0; j < 3; j++) if (color[i][j] > mx) mx = color[i][j];
              acc[0] = sat_accumulate(acc[0], w * longint'((mx >>> 1) + strength[i]));
            end else begin
              acc[0] = sat_accumulate(acc[0], w * longint'(strength[i]));
              for (int j = 0; j < 3; j++)
                acc[j+1] = sat_accumulate(acc[j+1], w * longint'(color[i][j]));
            end
          end
          for (int k = 0; k < 4; k++) e.sums[k] = acc[k][15:0];
        end
        default: ;
      endcase
      pending = {pending, e};
    endfunction

    function automatic void check_result(tint_resp_t a);
      tint_resp_t e;
      string names [4];
      names = '{"ambient_sum", "red_sum", "green_sum", "blue_sum"};
      n_resp++;
      if (pending.size() == 0) begin
        $error("response with no transaction outstanding");
        n_errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        n_errors++;
      end
      for (int k = 0; k < 4; k++)
        if (a.sums[k] !== e.sums[k]) begin
          $error("%s: expected %0d, got %0d", names[k], e.sums[k], a.sums[k]);
          n_errors++;
        end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = '0;
  logic [HalfW-1:0] center_x_half_i = '0;
  logic [HalfW-1:0] center_y_half_i = '0;
  logic [ReachW-1:0] reach_i = '0;
  logic signed [TintW-1:0] intensity_i = '0;
  logic signed [TintW-1:0] red_weight_i = '0;
  logic signed [TintW-1:0] green_weight_i = '0;
  logic signed [TintW-1:0] blue_weight_i = '0;
  logic [CellW-1:0] cell_x_i = '0;
  logic [CellW-1:0] cell_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic signed [TintW-1:0] ambient_sum_o, red_sum_o, green_sum_o, blue_sum_o;

  tint_scoreboard sb = new();
  bit idle_gaps;        // when clear, neither side inserts idle cycles
  bit hold_request;     // asks the receiver for one long stall
  int unsigned n_sent;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  point_light_tint_accumulator_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .kind_i, .center_x_half_i, .center_y_half_i,
    .reach_i, .intensity_i, .red_weight_i, .green_weight_i, .blue_weight_i,
    .cell_x_i, .cell_y_i,
    .out_valid_o, .out_ready_i, .status_o,
    .ambient_sum_o, .red_sum_o, .green_sum_o, .blue_sum_o
  );

  // Responses are checked at the rising edge where the handshake completes.
  always @(posedge clk_i) begin
    tint_resp_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a.status = status_o;
      a.sums[0] = ambient_sum_o;
      a.sums[1] = red_sum_o;
      a.sums[2] = green_sum_o;
      a.sums[3] = blue_sum_o;
      sb.check_result(a);
    end
  end

  // Receiver: a random number of idle cycles before each response while gaps
  // are enabled, and one long stall on request so that the output register
  // and the input side back up while the sender keeps offering transactions.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i = 1'b0;
        repeat (600) @(negedge clk_i);
      end
      gap = idle_gaps ? $urandom_range(17) : 0;
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Sends one transaction, after a random idle gap if gaps are enabled, and waits for acceptance.
  task automatic send(light_req_t q);
    int unsigned gap;
    gap = idle_gaps ? $urandom_range(17) : 0;
    repeat (gap) @(negedge clk_i);
    kind_i = q.kind;
    center_x_half_i = q.cx;
    center_y_half_i = q.cy;
    reach_i = q.reach;
    intensity_i = q.inten;
    red_weight_i = q.red;
    green_weight_i = q.green;
    blue_weight_i = q.blue;
    cell_x_i = q.x;
    cell_y_i = q.y;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(q);
    n_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Holds off until every response has arrived, then lets the block settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_mode(bit m);
    drain();
    cfg_wdata_i = m;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.ambient_only = m;
  endtask

  function automatic light_req_t add_req(int cx, int cy, int rch, int it, int r, int g,
                                         int b);
    light_req_t q;
    q = '{kind: KIND_ADD, cx: 10'(cx), cy: 10'(cy), reach: 16'(rch), inten: 16'(it),
          red: 16'(r), green: 16'(g), blue: 16'(b),
          x: 9'($urandom), y: 9'($urandom)};
    return q;
  endfunction

  function automatic light_req_t eval_req(int x, int y, logic [1:0] k = KIND_EVAL);
    light_req_t q;
    q = '{kind: k, cx: 10'($urandom), cy: 10'($urandom), reach: 16'($urandom),
          inten: 16'($urandom), red: 16'($urandom), green: 16'($urandom),
          blue: 16'($urandom), x: 9'(x), y: 9'(y)};
    return q;
  endfunction

  // Random transaction. Most lights sit around a focus point with a reach
  // that lets them cover the evaluated cells, some are placed anywhere.
  function automatic light_req_t rand_req(int fx, int fy);
    light_req_t q;
    int unsigned sel;
    int cx, cy;
    sel = $urandom_range(99);
    q = eval_req($urandom, $urandom);
    if (sel < 3) begin
      q.kind = KIND_CLEAR;
    end else if (sel < 55) begin
      q.kind = KIND_ADD;
      if ($urandom_range(4) != 0) begin
        cx = fx + int'($urandom_range(80)) - 40;
        cy = fy + int'($urandom_range(80)) - 40;
        q.cx = 10'(cx);
        q.cy = 10'(cy);
        q.reach = ($urandom_range(3) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(65535, 4000));
      end
      if ($urandom_range(7) == 0) q.inten = 16'(int'($urandom_range(12)) - 6);
    end else if (sel < 96) begin
      if ($urandom_range(4) != 0) begin
        q.x = 9'((fx >> 1) + int'($urandom_range(20)) - 10);
        q.y = 9'((fy >> 1) + int'($urandom_range(20)) - 10);
      end
    end else begin
      q.kind = KindUnused;
    end
    return q;
  endfunction

  initial begin
    int fx, fy;
    idle_gaps = 1'b1;
    hold_request = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, unused kind, weak and zero-reach lights,
    // field extremes, saturation, and a full table.
    set_mode(1'b0);
    send(eval_req(0, 0));
    send(eval_req(511, 511, KindUnused));
    send(add_req(0, 0, 65535, 4, 100, 100, 100));
    send(add_req(0, 0, 65535, -4, 100, 100, 100));
    send(add_req(0, 0, 65535, 0, 100, 100, 100));
    send(add_req(0, 0, 65535, 5, 32767, -32768, 0));
    send(add_req(0, 0, 65535, -5, -1, 1, 32767));
    send(add_req(1023, 1023, 65535, -32768, -32768, -32768, -32768));
    send(add_req(10, 10, 0, 32767, 32767, 32767, 32767));
    send(add_req(0, 0, 1, 32767, 32767, 32767, 32767));
    send(eval_req(0, 0));
    send(eval_req(511, 511));
    send(eval_req(5, 5));
    set_mode(1'b1);
    send(eval_req(0, 0));
    send(eval_req(511, 511));
    for (int i = 0; i < 26; i++) send(add_req(2, 2, 65535, 32767, 30000, -30000, 12));
    send(add_req(2, 2, 65535, 32767, 1, 1, 1));
    send(eval_req(1, 1));
    set_mode(1'b0);
    send(eval_req(1, 1));
    send(add_req(1023, 0, 65535, -32768, -32768, -32768, -32768));
    send(eval_req(0, 0));
    send(eval_req(511, 0, KIND_CLEAR));
    send(eval_req(1, 1));

    // Random phases, alternating the lighting mode; one phase runs without
    // idle cycles and one includes a long receiver stall.
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0]);
      idle_gaps = (ph != 3);
      fx = $urandom_range(1023);
      fy = $urandom_range(1023);
      if (ph == 2) hold_request = 1'b1;
      for (int n = 0; n < 105; n++) send(rand_req(fx, fy));
    end

    drain();
    repeat (2000) @(posedge clk_i);
    $display("Sent %0d transactions: %0d adds (%0d refused as full), %0d evaluations.",
             n_sent, sb.n_add, sb.n_full, sb.n_eval);
    $display("Evaluations summed %0d in-reach lights over %0d responses.",
             sb.n_hits, sb.n_resp);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("point_light_tint_accumulator_unit_test: clean");
    end else begin
      $display("point_light_tint_accumulator_unit_test: errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #(8 * 5000000);
    $display("point_light_tint_accumulator_unit_test: errors");
    $finish;
  end

endmodule
